@@ hdl/glw_pkg.sv @@
// Shared types, constants and helpers for the glyph layout block.
// Depends on nothing; imported by glw_pen and glyph_layout_with_wrap.
`default_nettype none

package glw_pkg;

  // Number of glyph table entries, starting at the first printable code.
  localparam int GLYPH_COUNT = 95;
  localparam int GLYPH_AW    = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;

  localparam logic [7:0] FIRST_CODE   = 8'd32;
  localparam logic [7:0] LAST_CODE    = 8'd126;
  localparam logic [7:0] NEWLINE_CODE = 8'd10;

  // Operation codes of an input request.
  localparam logic OP_TABLE_WRITE = 1'b0;
  localparam logic OP_LAYOUT      = 1'b1;

  // Configuration register indexes.
  localparam logic [2:0] CFG_MIN_X  = 3'd0;
  localparam logic [2:0] CFG_MIN_Y  = 3'd1;
  localparam logic [2:0] CFG_MAX_X  = 3'd2;
  localparam logic [2:0] CFG_MAX_Y  = 3'd3;
  localparam logic [2:0] CFG_LINE_H = 3'd4;

  typedef struct packed {
    logic [11:0]        atlas_x;
    logic [11:0]        atlas_y;
    logic signed [7:0]  offset_x;
    logic signed [7:0]  offset_y;
    logic [7:0]         advance;
    logic [7:0]         width;
  } glyph_t;

  localparam int GLYPH_W = $bits(glyph_t);

  typedef struct packed {
    logic signed [15:0] min_x;
    logic signed [15:0] min_y;
    logic signed [15:0] max_x;
    logic signed [15:0] max_y;
    logic [7:0]         line_h;
  } cfg_t;

  typedef struct packed {
    logic       op;
    logic       first;
    logic [7:0] code;
  } req_t;

  typedef struct packed {
    logic               draw_valid;
    logic [11:0]        src_x;
    logic [11:0]        src_y;
    logic [7:0]         quad_width;
    logic signed [15:0] dest_x;
    logic signed [15:0] dest_y;
    logic signed [15:0] extent_max_x;
    logic signed [15:0] extent_max_y;
    logic               stopped;
  } res_t;

  // True if the code has a glyph table entry.
  function automatic logic glyph_ok(input logic [7:0] code);
    logic [8:0] rel;
    rel = {1'b0, code} - {1'b0, FIRST_CODE};
    return (code >= FIRST_CODE) && (code <= LAST_CODE) &&
           (rel < 9'(GLYPH_COUNT));
  endfunction

  // Table address of a code; zero for codes without an entry.
  function automatic logic [GLYPH_AW-1:0] glyph_addr(input logic [7:0] code);
    logic [8:0] rel;
    rel = {1'b0, code} - {1'b0, FIRST_CODE};
    return glyph_ok(code) ? rel[GLYPH_AW-1:0] : '0;
  endfunction

endpackage

`default_nettype wire

@@ hdl/glw_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
`default_nettype none

module glw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ hdl/glw_pen.sv @@
// Pen, extent and halt state with the per-character layout logic.
// Depends on glw_pkg for the request, glyph, config and result types.
`default_nettype none

module glw_pen
  import glw_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   step,
  input  wire req_t   req,
  input  wire glyph_t glyph,
  input  wire cfg_t   cfg,
  output res_t        res
);

  logic signed [15:0] pen_x_r, pen_x_nxt;
  logic signed [15:0] pen_y_r, pen_y_nxt;
  logic signed [15:0] ext_r, ext_nxt;
  logic               halt_r, halt_nxt;

  logic signed [15:0] px0, py0, er0, px1, py1, py_nl;
  logic               h0, xbound, ybound, ok, wrap;
  logic signed [16:0] wrap_sum, np;

  always_comb begin
    ok     = glyph_ok(req.code);
    xbound = cfg.max_x > cfg.min_x;
    ybound = cfg.max_y > cfg.min_y;

    // Start of string: park the pen at the box corner first.
    if (req.first) begin
      px0 = cfg.min_x;
      py0 = cfg.min_y;
      er0 = cfg.max_x;
      h0  = 1'b0;
    end else begin
      px0 = pen_x_r;
      py0 = pen_y_r;
      er0 = ext_r;
      h0  = halt_r;
    end

    py_nl    = py0 + $signed({8'd0, cfg.line_h});
    wrap_sum = {px0[15], px0} + $signed({9'd0, glyph.advance});
    wrap     = ok && xbound && (wrap_sum >= $signed({cfg.max_x[15], cfg.max_x}));
    px1      = wrap ? cfg.min_x : px0;
    py1      = wrap ? py_nl : py0;
    np       = {px1[15], px1} + $signed({9'd0, glyph.advance});

    pen_x_nxt = pen_x_r;
    pen_y_nxt = pen_y_r;
    ext_nxt   = ext_r;
    halt_nxt  = halt_r;
    res       = '0;

    if (req.op == OP_LAYOUT) begin
      pen_x_nxt = px0;
      pen_y_nxt = py0;
      ext_nxt   = er0;
      halt_nxt  = h0;
      if (!h0) begin
        if (req.code == NEWLINE_CODE) begin
          pen_x_nxt = cfg.min_x;
          pen_y_nxt = py_nl;
        end else if (!ok && xbound) begin
          // drop the code
        end else begin
          pen_x_nxt = px1;
          pen_y_nxt = py1;
          if (ybound && (py1 >= cfg.max_y)) begin
            halt_nxt = 1'b1;
          end else if (ok) begin
            res.draw_valid = 1'b1;
            res.src_x      = glyph.atlas_x;
            res.src_y      = glyph.atlas_y;
            res.quad_width = glyph.width;
            res.dest_x     = px1 + 16'(glyph.offset_x);
            res.dest_y     = py1 + 16'(glyph.offset_y);
            if (np > $signed({er0[15], er0})) begin
              ext_nxt = np[15:0];
            end
            pen_x_nxt = np[15:0];
          end
        end
      end
    end

    res.extent_max_x = ext_nxt;
    res.extent_max_y = pen_y_nxt + $signed({8'd0, cfg.line_h});
    res.stopped      = halt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_x_r <= '0;
      pen_y_r <= '0;
      ext_r   <= '0;
      halt_r  <= 1'b0;
    end else if (step) begin
      pen_x_r <= pen_x_nxt;
      pen_y_r <= pen_y_nxt;
      ext_r   <= ext_nxt;
      halt_r  <= halt_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/glyph_layout_with_wrap.sv @@
// Glyph layout with wrapping: a request passes the glyph table read (stage 1),
// then layout into the output register. Throughput is one request per cycle
// unless out_stall holds the output; the pen state update is combinational,
// so consecutive characters chain without bubbles.
// Reset (rst_n low, synchronous) clears the pen, extent, halt flag, config and
// pipeline valids; the glyph table holds no reset and must be written first.
`default_nettype none

module glyph_layout_with_wrap
  import glw_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  // Configuration write port
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  // Request channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_operation,
  input  wire logic               in_first_of_string,
  input  wire logic [7:0]         in_char_code,
  input  wire logic [11:0]        in_glyph_atlas_x,
  input  wire logic [11:0]        in_glyph_atlas_y,
  input  wire logic signed [7:0]  in_glyph_offset_x,
  input  wire logic signed [7:0]  in_glyph_offset_y,
  input  wire logic [7:0]         in_glyph_advance,
  input  wire logic [7:0]         in_glyph_width,
  // Result channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_draw_valid,
  output logic [11:0]             out_src_x,
  output logic [11:0]             out_src_y,
  output logic [7:0]              out_quad_width,
  output logic signed [15:0]      out_dest_x,
  output logic signed [15:0]      out_dest_y,
  output logic signed [15:0]      out_extent_max_x,
  output logic signed [15:0]      out_extent_max_y,
  output logic                    out_stopped
);

  // Configuration registers; the user must write them only while the block is idle (not enforced here).
  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_X:  cfg_r.min_x  <= cfg_data;
        CFG_MIN_Y:  cfg_r.min_y  <= cfg_data;
        CFG_MAX_X:  cfg_r.max_x  <= cfg_data;
        CFG_MAX_Y:  cfg_r.max_y  <= cfg_data;
        CFG_LINE_H: cfg_r.line_h <= cfg_data[7:0];
        default:    ;  // unknown index: ignore the write
      endcase
    end
  end

  // Pipeline control. Stage 1 holds the request while the glyph entry is read;
  // the output register holds the finished result, so stage 1 can refill while
  // the consumer stalls, as long as one of the two slots frees up.
  logic  s1_valid_r, s1_valid_nxt;
  logic  out_valid_r;
  logic  out_free, in_fire, s1_fire;
  req_t  s1_req_r;
  res_t  out_r;
  res_t  step_res;
  glyph_t rd_glyph;
  glyph_t wr_glyph;
  logic  tbl_we;
  logic [GLYPH_W-1:0] rd_bits;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_fire  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // Table writes land at accept time; a layout request right behind reads the
  // fresh entry because its read happens at the following edge.
  assign tbl_we = in_fire && (in_operation == OP_TABLE_WRITE) && glyph_ok(in_char_code);

  always_comb begin
    wr_glyph.atlas_x  = in_glyph_atlas_x;
    wr_glyph.atlas_y  = in_glyph_atlas_y;
    wr_glyph.offset_x = in_glyph_offset_x;
    wr_glyph.offset_y = in_glyph_offset_y;
    wr_glyph.advance  = in_glyph_advance;
    wr_glyph.width    = in_glyph_width;
  end

  glw_ram #(
    .WIDTH (GLYPH_W),
    .DEPTH (GLYPH_COUNT),
    .AW    (GLYPH_AW)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (glyph_addr(in_char_code)),
    .wdata (wr_glyph),
    .re    (in_fire),
    .raddr (glyph_addr(in_char_code)),
    .rdata (rd_bits)
  );

  assign rd_glyph = rd_bits;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
    if (in_fire) begin
      s1_req_r.op    <= in_operation;
      s1_req_r.first <= in_first_of_string;
      s1_req_r.code  <= in_char_code;
    end
  end

  // Layout step: advance the pen state as the request moves into the output.
  glw_pen u_pen (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (s1_fire),
    .req   (s1_req_r),
    .glyph (rd_glyph),
    .cfg   (cfg_r),
    .res   (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
    if (s1_fire) begin
      out_r <= step_res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_draw_valid   = out_r.draw_valid;
  assign out_src_x        = out_r.src_x;
  assign out_src_y        = out_r.src_y;
  assign out_quad_width   = out_r.quad_width;
  assign out_dest_x       = out_r.dest_x;
  assign out_dest_y       = out_r.dest_y;
  assign out_extent_max_x = out_r.extent_max_x;
  assign out_extent_max_y = out_r.extent_max_y;
  assign out_stopped      = out_r.stopped;

endmodule

`default_nettype wire
